[design/pnlr_pkg.sv]
// ----------------------------------------------------------------------------
// pnlr_pkg
// Shared types and fixed widths of the packed-nibble line rasterizer.
// ----------------------------------------------------------------------------
package pnlr_pkg;

    localparam int X_W     = 8;
    localparam int Y_W     = 7;
    localparam int COLOR_W = 4;
    localparam int BA_W    = 14;
    localparam int REQ_W   = 2;
    localparam int D2_W    = X_W + 1;
    localparam int ERR_W   = D2_W + 3;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_DRAW  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // Input beat payload, last field (start_x) in the lowest bits.
    typedef struct packed {
        logic [BA_W-1:0]    byte_addr;
        logic [COLOR_W-1:0] color;
        logic [Y_W-1:0]     end_y;
        logic [X_W-1:0]     end_x;
        logic [Y_W-1:0]     start_y;
        logic [X_W-1:0]     start_x;
    } req_fields_t;

    // Current pixel position and error term.
    typedef struct packed {
        logic [X_W-1:0]          x;
        logic [Y_W-1:0]          y;
        logic signed [ERR_W-1:0] err;
    } bres_pos_t;

    // Per-line constants of the stepper.
    typedef struct packed {
        logic            xmaj;
        logic            x_dec;
        logic            y_dec;
        logic [D2_W-1:0] d_maj2;
        logic [D2_W-1:0] d_min2;
        logic [X_W-1:0]  end_x;
        logic [Y_W-1:0]  end_y;
    } bres_ctl_t;

endpackage

[design/pnlr_bres_step.sv]
// ----------------------------------------------------------------------------
// pnlr_bres_step
// One Bresenham step: next position and error term, plus end-of-line detect.
// ----------------------------------------------------------------------------
module pnlr_bres_step (
    input  pnlr_pkg::bres_ctl_t ctl,
    input  pnlr_pkg::bres_pos_t cur,
    output pnlr_pkg::bres_pos_t nxt,
    output logic                at_end
);
    import pnlr_pkg::*;

    logic                    minor_step;
    logic signed [ERR_W-1:0] e_adj;
    logic [X_W-1:0]          x_inc;
    logic [Y_W-1:0]          y_inc;

    always_comb begin
        minor_step = !cur.err[ERR_W-1];
        e_adj      = minor_step ? cur.err - $signed(ERR_W'(ctl.d_maj2)) : cur.err;
        nxt.err    = e_adj + $signed(ERR_W'(ctl.d_min2));
        x_inc      = ctl.x_dec ? cur.x - X_W'(1) : cur.x + X_W'(1);
        y_inc      = ctl.y_dec ? cur.y - Y_W'(1) : cur.y + Y_W'(1);
        nxt.x      = (ctl.xmaj || minor_step) ? x_inc : cur.x;
        nxt.y      = (!ctl.xmaj || minor_step) ? y_inc : cur.y;
        at_end     = ctl.xmaj ? (cur.x == ctl.end_x) : (cur.y == ctl.end_y);
    end

endmodule

[design/packed_nibble_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// packed_nibble_line_rasterizer
// Frame store of 4-bit pixels, two per byte, with line draw, read and clear.
// ----------------------------------------------------------------------------
// Requests arrive as beats on s_*: s_tuser is the request kind (draw, read,
// clear), s_tdata carries endpoints, color and byte address. Every request
// returns exactly one beat on m_*: read_data (byte for a read, else 0) and
// clipped (a draw skipped off-screen pixels).
// States per request, accept to result ready, each ending in ST_DONE:
//   draw  : ST_SETUP, then ST_PIX_RD and ST_PIX_WR per on-screen pixel,
//           ST_PIX_RD alone per off-screen pixel
//   read  : ST_READ; clear: ST_CLEAR, one byte zeroed per cycle
//   other : straight to ST_DONE
// Each on-screen pixel is a read then a write of the frame store; the
// shared stepper advances once per pixel. s_tready is high only between
// requests. The result register holds a beat until m_tready; the next request
// is taken meanwhile and its result waits for the register to free up.
// Reset clears control only; the frame store is undefined until drawn or
// cleared.
// ----------------------------------------------------------------------------
module packed_nibble_line_rasterizer #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 108,
    parameter int FRAME_BYTES   = 8640
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // start_x, start_y, end_x, end_y, color, byte_addr
    input  logic [pnlr_pkg::IN_W-1:0]   s_tdata,
    // req_type
    input  logic [pnlr_pkg::REQ_W-1:0]  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // read_data, clipped, zero pad
    output logic [pnlr_pkg::OUT_W-1:0]  m_tdata
);
    import pnlr_pkg::*;

    localparam int ROW_BYTES = (SCREEN_WIDTH + 1) / 2;
    localparam int AW        = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int PROD_W    = Y_W + $clog2(ROW_BYTES + 1);
    localparam int PA_W      = ((PROD_W > AW) ? PROD_W : AW) + 1;
    localparam int RA_W      = ((BA_W > AW) ? BA_W : AW) + 1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SETUP  = 7'b0000010,
        ST_PIX_RD = 7'b0000100,
        ST_PIX_WR = 7'b0001000,
        ST_CLEAR  = 7'b0010000,
        ST_READ   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic                m_valid_reg, m_valid_next;
    logic [8:0]          m_data_reg, m_data_next;
    bres_pos_t           pos_reg, pos_next;
    bres_ctl_t           ctl_reg, ctl_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic [BA_W-1:0]     baddr_reg, baddr_next;
    logic                clip_reg, clip_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [AW-1:0]       pa_reg, pa_next;
    logic                nib_lo_reg, nib_lo_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [7:0]          rd_data_reg;

    logic [7:0]          mem [FRAME_BYTES];
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_wa, mem_ra;
    logic [7:0]          mem_wd;

    req_fields_t         req_in;
    bres_pos_t           step_pos;
    logic                at_end;
    logic                advance;
    logic [PA_W-1:0]     pix_addr;
    logic                pix_off;
    logic [RA_W-1:0]     rd_addr;
    logic                rd_in_range;
    logic [X_W-1:0]      adx;
    logic [Y_W-1:0]      ady;
    logic [D2_W-1:0]     dx2, dy2;
    logic                xmaj;

    assign req_in = req_fields_t'(s_tdata);

    pnlr_bres_step u_step (
        .ctl    (ctl_reg),
        .cur    (pos_reg),
        .nxt    (step_pos),
        .at_end (at_end)
    );

    always_comb begin
        pix_addr = PA_W'(pos_reg.y) * PA_W'(ROW_BYTES) + PA_W'(pos_reg.x[X_W-1:1]);
        pix_off  = (int'(pos_reg.x) >= SCREEN_WIDTH) || (int'(pos_reg.y) >= SCREEN_HEIGHT)
                   || (pix_addr >= PA_W'(FRAME_BYTES));
        rd_addr     = RA_W'(baddr_reg);
        rd_in_range = rd_addr < RA_W'(FRAME_BYTES);
        adx  = (ctl_reg.end_x >= pos_reg.x) ? ctl_reg.end_x - pos_reg.x
                                            : pos_reg.x - ctl_reg.end_x;
        ady  = (ctl_reg.end_y >= pos_reg.y) ? ctl_reg.end_y - pos_reg.y
                                            : pos_reg.y - ctl_reg.end_y;
        dx2  = {adx, 1'b0};
        dy2  = {1'b0, ady, 1'b0};
        xmaj = adx > X_W'(ady);
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        pos_next     = pos_reg;
        ctl_next     = ctl_reg;
        color_next   = color_reg;
        baddr_next   = baddr_reg;
        clip_next    = clip_reg;
        rd_ok_next   = rd_ok_reg;
        pa_next      = pa_reg;
        nib_lo_next  = nib_lo_reg;
        clr_cnt_next = clr_cnt_reg;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_wd       = '0;
        mem_re       = 1'b0;
        mem_ra       = '0;
        advance      = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    pos_next.x     = req_in.start_x;
                    pos_next.y     = req_in.start_y;
                    pos_next.err   = '0;
                    ctl_next.end_x = req_in.end_x;
                    ctl_next.end_y = req_in.end_y;
                    color_next     = req_in.color;
                    baddr_next     = req_in.byte_addr;
                    clip_next      = 1'b0;
                    rd_ok_next     = 1'b0;
                    clr_cnt_next   = '0;
                    case (req_t'(s_tuser))
                        REQ_DRAW:  state_next = ST_SETUP;
                        REQ_READ:  state_next = ST_READ;
                        REQ_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_SETUP: begin
                ctl_next.xmaj   = xmaj;
                ctl_next.x_dec  = ctl_reg.end_x < pos_reg.x;
                ctl_next.y_dec  = ctl_reg.end_y < pos_reg.y;
                ctl_next.d_maj2 = xmaj ? dx2 : dy2;
                ctl_next.d_min2 = xmaj ? dy2 : dx2;
                pos_next.err    = xmaj ? ERR_W'(dy2) - ERR_W'(adx)
                                       : ERR_W'(dx2) - ERR_W'(ady);
                state_next      = ST_PIX_RD;
            end
            ST_PIX_RD: begin
                if (pix_off) begin
                    clip_next = 1'b1;
                    advance   = 1'b1;
                end else begin
                    mem_re      = 1'b1;
                    mem_ra      = pix_addr[AW-1:0];
                    pa_next     = pix_addr[AW-1:0];
                    nib_lo_next = pos_reg.x[0];
                    state_next  = ST_PIX_WR;
                end
            end
            ST_PIX_WR: begin
                mem_we  = 1'b1;
                mem_wa  = pa_reg;
                mem_wd  = nib_lo_reg ? {rd_data_reg[7:4], color_reg}
                                     : {color_reg, rd_data_reg[3:0]};
                advance = 1'b1;
            end
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = clr_cnt_reg;
                mem_wd = '0;
                if (clr_cnt_reg == AW'(FRAME_BYTES - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            ST_READ: begin
                if (rd_in_range) begin
                    mem_re     = 1'b1;
                    mem_ra     = rd_addr[AW-1:0];
                    rd_ok_next = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {clip_reg, rd_ok_reg ? rd_data_reg : 8'h00};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (advance) begin
            if (at_end) begin
                state_next = ST_DONE;
            end else begin
                pos_next   = step_pos;
                state_next = ST_PIX_RD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        pos_reg     <= pos_next;
        ctl_reg     <= ctl_next;
        color_reg   <= color_next;
        baddr_reg   <= baddr_next;
        clip_reg    <= clip_next;
        rd_ok_reg   <= rd_ok_next;
        pa_reg      <= pa_next;
        nib_lo_reg  <= nib_lo_next;
        clr_cnt_reg <= clr_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_data_reg};

    a_no_write_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !s_tready)
        else $error("frame store written while idle");

    a_one_beat_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat taken before request finished");

    a_result_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !m_valid_reg) |=> m_valid_reg)
        else $error("result not loaded into free output register");

    a_clip_only_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> (m_tdata[7:0] == 8'h00))
        else $error("clipped flag with nonzero read data");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the packed-nibble line rasterizer against a software mirror of its
// frame store. Requests go in on s_* from a queue of pending beats: a short
// directed set first (clear, extreme and reversed lines, a single-pixel line,
// off-screen endpoints, out-of-range reads, the unused request code), then
// random requests, mostly on-screen lines. Each accepted request is predicted
// when it is taken, and every result beat on m_* is compared field by field
// with the oldest prediction. Both sides idle at random, and once the result
// side holds off long enough that the input side stalls.
// ----------------------------------------------------------------------------
module testbench;
    import pnlr_pkg::*;

    localparam int SCR_W       = 160;
    localparam int SCR_H       = 108;
    localparam int FRAME_BYTES = 8640;
    localparam int FB_AW       = $clog2(FRAME_BYTES);
    localparam int ROW_BYTES   = (SCR_W + 1) / 2;
    localparam int N_ITEMS     = 1810;
    localparam int MAX_CYCLES  = 5_000_000;

    typedef struct {
        req_t        kind;
        req_fields_t f;
    } raster_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       clipped;
    } raster_out_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata  = '0;
    logic [REQ_W-1:0]   s_tuser  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;

    logic [7:0]         pixel_bytes [FRAME_BYTES];
    raster_req_t        pending [$];
    raster_out_t        due_results [$];

    logic               s_taken = 1'b0;
    logic               m_taken = 1'b0;
    int                 n_errors  = 0;
    int                 n_results = 0;
    int                 n_cycles  = 0;

    packed_nibble_line_rasterizer #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H),
        .FRAME_BYTES   (FRAME_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // ---- frame store mirror ----

    function automatic bit plot_nibble(int px, int py, logic [3:0] c);
        int a;
        logic [FB_AW-1:0] ai;
        if (px < 0 || py < 0 || px >= SCR_W || py >= SCR_H) return 1'b1;
        a = py * ROW_BYTES + (px >> 1);
        if (a >= FRAME_BYTES) return 1'b1;
        ai = FB_AW'(a);
        if ((px & 1) == 0)
            pixel_bytes[ai] = {c, pixel_bytes[ai][3:0]};
        else
            pixel_bytes[ai] = {pixel_bytes[ai][7:4], c};
        return 1'b0;
    endfunction

    function automatic bit trace_line(int x, int y, int xe, int ye, logic [3:0] c);
        int dx, dy, sx, sy, err;
        bit clip;
        dx = xe - x;
        dy = ye - y;
        sx = 1;
        sy = 1;
        if (dy < 0) begin
            dy = -dy;
            sy = -1;
        end
        if (dx < 0) begin
            dx = -dx;
            sx = -1;
        end
        dx = dx * 2;
        dy = dy * 2;
        clip = plot_nibble(x, y, c);
        if (dx > dy) begin
            err = dy - dx / 2;
            while (x != xe) begin
                if (err >= 0) begin
                    y += sy;
                    err -= dx;
                end
                x += sx;
                err += dy;
                if (plot_nibble(x, y, c)) clip = 1'b1;
            end
        end else begin
            err = dx - dy / 2;
            while (y != ye) begin
                if (err >= 0) begin
                    x += sx;
                    err -= dy;
                end
                y += sy;
                err += dx;
                if (plot_nibble(x, y, c)) clip = 1'b1;
            end
        end
        return clip;
    endfunction

    function automatic raster_out_t predict_result(req_t kind, req_fields_t f);
        raster_out_t o;
        o = '0;
        case (kind)
            REQ_DRAW: begin
                o.clipped = trace_line(int'(f.start_x), int'(f.start_y),
                                       int'(f.end_x), int'(f.end_y), f.color);
            end
            REQ_READ: begin
                if (f.byte_addr < FRAME_BYTES) o.read_data = pixel_bytes[f.byte_addr];
            end
            REQ_CLEAR: begin
                foreach (pixel_bytes[i]) pixel_bytes[i] = 8'h00;
            end
            default: ;
        endcase
        return o;
    endfunction

    // ---- stimulus ----

    function automatic void queue_req(req_t kind, int sx, int sy, int ex, int ey,
                                      int col, int addr);
        raster_req_t r;
        r.kind        = kind;
        r.f.start_x   = X_W'(sx);
        r.f.start_y   = Y_W'(sy);
        r.f.end_x     = X_W'(ex);
        r.f.end_y     = Y_W'(ey);
        r.f.color     = COLOR_W'(col);
        r.f.byte_addr = BA_W'(addr);
        pending.push_back(r);
    endfunction

    function automatic raster_req_t random_req();
        raster_req_t r;
        int k, mode, x0, y0;
        r.f.start_x   = X_W'($urandom);
        r.f.start_y   = Y_W'($urandom);
        r.f.end_x     = X_W'($urandom);
        r.f.end_y     = Y_W'($urandom);
        r.f.color     = COLOR_W'($urandom);
        r.f.byte_addr = BA_W'($urandom);
        k = $urandom_range(0, 199);
        if (k < 2)       r.kind = REQ_CLEAR;
        else if (k < 8)  r.kind = REQ_NONE;
        else if (k < 80) r.kind = REQ_READ;
        else             r.kind = REQ_DRAW;
        if (r.kind == REQ_READ && $urandom_range(0, 99) < 85)
            r.f.byte_addr = BA_W'($urandom_range(0, FRAME_BYTES - 1));
        if (r.kind == REQ_DRAW) begin
            mode = $urandom_range(0, 9);
            if (mode < 6) begin
                // short line around an on-screen point
                x0 = $urandom_range(8, SCR_W - 9);
                y0 = $urandom_range(8, SCR_H - 9);
                r.f.start_x = X_W'(x0);
                r.f.start_y = Y_W'(y0);
                r.f.end_x   = X_W'(x0 + $urandom_range(0, 16) - 8);
                r.f.end_y   = Y_W'(y0 + $urandom_range(0, 16) - 8);
            end else if (mode < 9) begin
                r.f.start_x = X_W'($urandom_range(0, SCR_W - 1));
                r.f.start_y = Y_W'($urandom_range(0, SCR_H - 1));
                r.f.end_x   = X_W'($urandom_range(0, SCR_W - 1));
                r.f.end_y   = Y_W'($urandom_range(0, SCR_H - 1));
            end
        end
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // ---- request driver ----

    int          tx_wait  = 0;
    int          tx_burst = 0;
    raster_req_t tx_next;

    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_taken)) begin
            if (tx_wait > 0) begin
                tx_wait--;
                s_tvalid <= 1'b0;
            end else if (pending.size() > 0) begin
                tx_next = pending.pop_front();
                s_tuser  <= tx_next.kind;
                s_tdata  <= tx_next.f;
                s_tvalid <= 1'b1;
                tx_wait  = (tx_burst > 0) ? 0 : idle_len();
                if (tx_burst > 0)
                    tx_burst--;
                else if ($urandom_range(0, 49) == 0)
                    tx_burst = $urandom_range(10, 40);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---- result receiver ----

    int rx_wait   = 0;
    int rx_burst  = 0;
    int long_hold = 0;
    bit hold_done = 1'b0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!hold_done && n_results >= 150) begin
                long_hold = 1500;
                hold_done = 1'b1;
            end
            if (m_taken || (rx_wait == 0 && $urandom_range(0, 15) == 0)) begin
                rx_wait = (rx_burst > 0) ? 0 : idle_len();
                if (rx_burst > 0)
                    rx_burst--;
                else if ($urandom_range(0, 49) == 0)
                    rx_burst = $urandom_range(10, 40);
            end
            if (long_hold > 0) begin
                long_hold--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---- monitor and checker ----

    always @(posedge aclk) begin
        raster_out_t want;
        s_taken <= aresetn && s_tvalid && s_tready;
        m_taken <= aresetn && m_tvalid && m_tready;
        if (aresetn && s_tvalid && s_tready)
            due_results.push_back(predict_result(req_t'(s_tuser), req_fields_t'(s_tdata)));
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (due_results.size() == 0) begin
                $error("result beat with no request outstanding: %h", m_tdata);
                n_errors++;
            end else begin
                want = due_results.pop_front();
                if (m_tdata[7:0] !== want.read_data) begin
                    $error("read_data: expected %h, actual %h", want.read_data, m_tdata[7:0]);
                    n_errors++;
                end
                if (m_tdata[8] !== want.clipped) begin
                    $error("clipped: expected %b, actual %b", want.clipped, m_tdata[8]);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles >= MAX_CYCLES) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        // store is undefined until cleared
        queue_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
        queue_req(REQ_READ, 0, 0, 0, 0, 0, 0);
        queue_req(REQ_DRAW, 0, 0, SCR_W - 1, SCR_H - 1, 15, 0);
        queue_req(REQ_READ, 0, 0, 0, 0, 0, 0);
        queue_req(REQ_DRAW, 5, 5, 5, 5, 10, 0);
        queue_req(REQ_READ, 0, 0, 0, 0, 0, 5 * ROW_BYTES + 2);
        queue_req(REQ_DRAW, 10, 0, 12, SCR_H - 1, 3, 0);
        queue_req(REQ_DRAW, SCR_W - 1, SCR_H - 1, 0, 0, 7, 0);
        queue_req(REQ_DRAW, 0, 50, SCR_W - 1, 50, 9, 0);
        queue_req(REQ_DRAW, SCR_W - 1, 0, SCR_W - 1, SCR_H - 1, 6, 0);
        queue_req(REQ_DRAW, 150, 100, 255, 127, 5, 0);
        queue_req(REQ_DRAW, 255, 127, 255, 127, 1, 0);
        queue_req(REQ_DRAW, 0, 0, 200, 10, 0, 0);
        queue_req(REQ_DRAW, 100, 120, 100, 0, 12, 0);
        queue_req(REQ_READ, 0, 0, 0, 0, 0, 50 * ROW_BYTES + 40);
        queue_req(REQ_READ, 0, 0, 0, 0, 0, FRAME_BYTES - 1);
        queue_req(REQ_READ, 0, 0, 0, 0, 0, FRAME_BYTES);
        queue_req(REQ_READ, 255, 127, 255, 127, 15, 16383);
        queue_req(REQ_NONE, 255, 127, 255, 127, 15, 16383);
        queue_req(REQ_READ, 0, 0, 0, 0, 0, 0);
        queue_req(REQ_CLEAR, 255, 127, 255, 127, 15, 16383);
        queue_req(REQ_READ, 0, 0, 0, 0, 0, 0);
        while (pending.size() < N_ITEMS) pending.push_back(random_req());

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (pending.size() != 0 || s_tvalid || due_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (n_errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
